### design/quorum_mutex_node_top_assert.svh
// Assertion macros for the quorum mutex node.
// Included by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef QUORUM_MUTEX_NODE_TOP_ASSERT_SVH
`define QUORUM_MUTEX_NODE_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define QMN_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define QMN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### design/qmn_pkg.sv
// Shared types and constants for the quorum mutex node.
// No dependencies; used by the controller, datapath, top level and testbench.
`default_nettype none

package qmn_pkg;

  localparam int QDEPTH     = 16;
  localparam int FIFO_DEPTH = 8;
  localparam int MAX_OUT    = 7;

  localparam logic [1:0] CFG_MY_ROW       = 2'd0;
  localparam logic [1:0] CFG_MY_COL       = 2'd1;
  localparam logic [1:0] CFG_IS_REQUESTER = 2'd2;

  typedef enum logic [2:0] {
    OP_START      = 3'd0,
    OP_REQUEST    = 3'd1,
    OP_LOCKED     = 3'd2,
    OP_FAILED     = 3'd3,
    OP_INQUIRE    = 3'd4,
    OP_RELINQUISH = 3'd5,
    OP_RELEASE    = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    K_REQUEST    = 3'd0,
    K_LOCKED     = 3'd1,
    K_FAILED     = 3'd2,
    K_INQUIRE    = 3'd3,
    K_RELINQUISH = 3'd4,
    K_RELEASE    = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_RD,
    S_POP,
    S_INS_RD,
    S_INS_CMP,
    S_REQ_RD,
    S_REQ_ANS,
    S_FLUSH,
    S_BCAST_REQ,
    S_QUORUM,
    S_BCAST_REL,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_DISPATCH,
    ACT_POP_RD,
    ACT_POP,
    ACT_INS_RD,
    ACT_INS_CMP,
    ACT_REQ_RD,
    ACT_REQ_ANS,
    ACT_FLUSH,
    ACT_BCAST,
    ACT_QUORUM,
    ACT_FINISH
  } act_t;

  typedef struct packed {
    logic [31:0] stamp;
    logic [3:0]  idx;
  } qent_t;

  typedef struct packed {
    logic [3:0]  dest;
    kind_t       kind;
    logic [31:0] stamp;
    logic        acq;
    logic        last;
  } res_t;

  typedef struct packed {
    act_t act;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic is_req;
    logic vote_given;
    logic q_empty;
    logic q_full;
    logic ins_front;
    logic after_hit;
    logic flush_done;
    logic bcast_last;
    logic quorum_hit;
    logic fifo_full;
  } sts_t;

  // a orders after b: later stamp, then higher index
  function automatic logic after(input qent_t a, input qent_t b);
    return (a.stamp > b.stamp) || ((a.stamp == b.stamp) && (a.idx > b.idx));
  endfunction

endpackage

`default_nettype wire

### design/qmn_in_if.sv
// Input message channel: valid/ready plus one message beat.
// Depends on nothing.
`default_nettype none

interface qmn_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [3:0]  sender_index;
  logic [31:0] stamp;

  modport source (output valid, output opcode, output sender_index, output stamp,
                  input ready);
  modport sink (input valid, input opcode, input sender_index, input stamp,
                output ready);
endinterface

`default_nettype wire

### design/qmn_out_if.sv
// Output message channel: valid/ready plus one outgoing message beat.
// Depends on nothing.
`default_nettype none

interface qmn_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  dest_index;
  logic [2:0]  msg_kind;
  logic [31:0] out_stamp;
  logic        acquired;
  logic        last;

  modport source (output valid, output dest_index, output msg_kind, output out_stamp,
                  output acquired, output last, input ready);
  modport sink (input valid, input dest_index, input msg_kind, input out_stamp,
                input acquired, input last, output ready);
endinterface

`default_nettype wire

### design/qmn_ctrl.sv
// Sequencer for the quorum mutex node: walks one message through its steps.
// Depends on qmn_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module qmn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qmn_pkg::sts_t sts,
  output qmn_pkg::cmd_t      cmd
);

  qmn_pkg::state_t state;
  qmn_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qmn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // after an insertion the request path still owes its answer
  function automatic qmn_pkg::state_t after_insert(input qmn_pkg::op_t op);
    return (op == qmn_pkg::OP_REQUEST) ? qmn_pkg::S_REQ_RD : qmn_pkg::S_QUORUM;
  endfunction

  always_comb begin
    state_next = state;
    if (state != qmn_pkg::S_IDLE && sts.fifo_full) begin
      state_next = state;
    end else begin
      unique case (state)
        qmn_pkg::S_IDLE: begin
          if (in_valid) state_next = qmn_pkg::S_DISPATCH;
        end
        qmn_pkg::S_DISPATCH: begin
          unique case (sts.op)
            qmn_pkg::OP_START:
              state_next = sts.is_req ? qmn_pkg::S_BCAST_REQ : qmn_pkg::S_QUORUM;
            qmn_pkg::OP_REQUEST: begin
              if (!sts.vote_given) state_next = qmn_pkg::S_QUORUM;
              else if (sts.q_full) state_next = qmn_pkg::S_REQ_RD;
              else state_next = qmn_pkg::S_INS_RD;
            end
            qmn_pkg::OP_LOCKED:  state_next = qmn_pkg::S_QUORUM;
            qmn_pkg::OP_FAILED:  state_next = qmn_pkg::S_FLUSH;
            qmn_pkg::OP_INQUIRE: state_next = qmn_pkg::S_QUORUM;
            qmn_pkg::OP_RELINQUISH, qmn_pkg::OP_RELEASE:
              state_next = sts.q_empty ? qmn_pkg::S_QUORUM : qmn_pkg::S_POP_RD;
            default: state_next = qmn_pkg::S_IDLE;
          endcase
        end
        qmn_pkg::S_POP_RD: state_next = qmn_pkg::S_POP;
        qmn_pkg::S_POP: begin
          state_next = (sts.op == qmn_pkg::OP_RELINQUISH) ? qmn_pkg::S_INS_RD
                                                         : qmn_pkg::S_QUORUM;
        end
        qmn_pkg::S_INS_RD: begin
          state_next = sts.ins_front ? after_insert(sts.op) : qmn_pkg::S_INS_CMP;
        end
        qmn_pkg::S_INS_CMP: begin
          state_next = sts.after_hit ? qmn_pkg::S_INS_RD : after_insert(sts.op);
        end
        qmn_pkg::S_REQ_RD:  state_next = qmn_pkg::S_REQ_ANS;
        qmn_pkg::S_REQ_ANS: state_next = qmn_pkg::S_QUORUM;
        qmn_pkg::S_FLUSH: begin
          if (sts.flush_done) state_next = qmn_pkg::S_QUORUM;
        end
        qmn_pkg::S_BCAST_REQ: begin
          if (sts.bcast_last) state_next = qmn_pkg::S_QUORUM;
        end
        qmn_pkg::S_QUORUM: begin
          state_next = sts.quorum_hit ? qmn_pkg::S_BCAST_REL : qmn_pkg::S_FINISH;
        end
        qmn_pkg::S_BCAST_REL: begin
          if (sts.bcast_last) state_next = qmn_pkg::S_FINISH;
        end
        qmn_pkg::S_FINISH: state_next = qmn_pkg::S_IDLE;
        default: state_next = qmn_pkg::S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready = (state == qmn_pkg::S_IDLE);
    cmd.act  = qmn_pkg::ACT_NONE;
    if (state == qmn_pkg::S_IDLE) begin
      if (in_valid) cmd.act = qmn_pkg::ACT_LATCH;
    end else if (!sts.fifo_full) begin
      unique case (state)
        qmn_pkg::S_DISPATCH:  cmd.act = qmn_pkg::ACT_DISPATCH;
        qmn_pkg::S_POP_RD:    cmd.act = qmn_pkg::ACT_POP_RD;
        qmn_pkg::S_POP:       cmd.act = qmn_pkg::ACT_POP;
        qmn_pkg::S_INS_RD:    cmd.act = qmn_pkg::ACT_INS_RD;
        qmn_pkg::S_INS_CMP:   cmd.act = qmn_pkg::ACT_INS_CMP;
        qmn_pkg::S_REQ_RD:    cmd.act = qmn_pkg::ACT_REQ_RD;
        qmn_pkg::S_REQ_ANS:   cmd.act = qmn_pkg::ACT_REQ_ANS;
        qmn_pkg::S_FLUSH:     cmd.act = qmn_pkg::ACT_FLUSH;
        qmn_pkg::S_BCAST_REQ: cmd.act = qmn_pkg::ACT_BCAST;
        qmn_pkg::S_QUORUM:    cmd.act = qmn_pkg::ACT_QUORUM;
        qmn_pkg::S_BCAST_REL: cmd.act = qmn_pkg::ACT_BCAST;
        qmn_pkg::S_FINISH:    cmd.act = qmn_pkg::ACT_FINISH;
        default:              cmd.act = qmn_pkg::ACT_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/qmn_datapath.sv
// Datapath of the quorum mutex node: vote, wait queue, grant tracking,
// broadcast counters and the result FIFO. Depends on qmn_pkg and the assert macros.
`default_nettype none
`include "quorum_mutex_node_top_assert.svh"

module qmn_datapath #(
  parameter int ROWS        = 4,
  parameter int DEFER_DEPTH = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire qmn_pkg::cmd_t cmd,
  output qmn_pkg::sts_t      sts,
  input  wire logic [2:0]    in_opcode,
  input  wire logic [3:0]    in_sender,
  input  wire logic [31:0]   in_stamp,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [1:0]    cfg_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [3:0]         out_dest,
  output logic [2:0]         out_kind,
  output logic [31:0]        out_stamp,
  output logic               out_acq,
  output logic               out_last
);

  localparam int BIW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DIW = (DEFER_DEPTH > 1) ? $clog2(DEFER_DEPTH) : 1;
  localparam int DCW = $clog2(DEFER_DEPTH + 1);
  localparam int QIW = $clog2(qmn_pkg::QDEPTH);
  localparam int QCW = $clog2(qmn_pkg::QDEPTH + 1);
  localparam int FIW = $clog2(qmn_pkg::FIFO_DEPTH);
  localparam int FCW = $clog2(qmn_pkg::FIFO_DEPTH + 1);
  localparam int OCW = $clog2(qmn_pkg::MAX_OUT + 1);
  localparam logic [4:0] QUORUM_SIZE = 5'(2 * ROWS - 1);

  // configuration
  logic [1:0] my_row;
  logic [1:0] my_col;
  logic       is_req;

  // latched message
  qmn_pkg::op_t op;
  logic [3:0]   snd;
  logic [31:0]  st;

  // voter state
  logic          vote_given;
  logic [3:0]    vote_holder;
  logic [31:0]   vote_holder_stamp;
  qmn_pkg::qent_t qmem [qmn_pkg::QDEPTH];
  qmn_pkg::qent_t q_rd;
  logic [QIW-1:0] q_head;
  logic [QCW-1:0] wait_count;
  logic [QCW-1:0] ins_k;

  // requester state
  logic [3:0]     dq [DEFER_DEPTH];
  logic [DCW-1:0] dcount;
  logic [DCW-1:0] fk;
  logic [15:0]    grant_map;
  logic [4:0]     grant_count;
  logic           failure_seen;
  logic [31:0]    own_stamp;
  logic           finished;

  // broadcast walker
  logic [BIW-1:0]  bi;
  logic            bphase;
  logic            bacq;
  qmn_pkg::kind_t  bkind;

  // result staging and FIFO
  qmn_pkg::res_t  staged;
  logic           staged_v;
  logic [OCW-1:0] ocount;
  qmn_pkg::res_t  fmem [qmn_pkg::FIFO_DEPTH];
  logic [FIW-1:0] wp;
  logic [FIW-1:0] rp;
  logic [FCW-1:0] fcnt;
  qmn_pkg::res_t  oreg;

  qmn_pkg::qent_t item;
  logic           after_hit;
  logic           head_higher;
  logic           send_inquire;
  logic           map_bit;
  logic [3:0]     d_cur;
  logic           flush_done;
  logic           brow_now;
  logic           bcast_last;
  logic [3:0]     bdest_row;
  logic [3:0]     bdest_col;
  logic           quorum_hit;
  logic           fifo_full;

  logic           emit_en;
  qmn_pkg::res_t  emit_res;
  logic           keep;
  logic           fifo_push;
  qmn_pkg::res_t  fifo_wdata;
  logic           load;

  logic           q_we;
  logic [QIW-1:0] q_waddr;
  qmn_pkg::qent_t q_wdata;
  logic [QIW-1:0] q_raddr;

  assign item         = '{stamp: st, idx: snd};
  assign after_hit    = qmn_pkg::after(q_rd, item);
  assign head_higher  = qmn_pkg::after(item, q_rd);
  assign send_inquire = !((vote_holder_stamp < st) || head_higher ||
                          ((vote_holder_stamp == st) && (vote_holder < snd)));
  assign map_bit      = grant_map[snd];
  assign d_cur        = dq[fk[DIW-1:0]];
  assign flush_done   = (fk >= dcount);
  assign brow_now     = !bphase && (int'(bi) != int'(my_col));
  assign bcast_last   = !brow_now && (int'(bi) == ROWS - 1);
  assign bdest_row    = 4'(int'(my_row) * ROWS + int'(bi));
  assign bdest_col    = 4'(int'(bi) * ROWS + int'(my_col));
  assign quorum_hit   = !finished && (grant_count == QUORUM_SIZE);
  assign fifo_full    = (fcnt == FCW'(qmn_pkg::FIFO_DEPTH));

  always_comb begin
    sts.op         = op;
    sts.is_req     = is_req;
    sts.vote_given = vote_given;
    sts.q_empty    = (wait_count == '0);
    sts.q_full     = (wait_count == QCW'(qmn_pkg::QDEPTH));
    sts.ins_front  = (ins_k == '0);
    sts.after_hit  = after_hit;
    sts.flush_done = flush_done;
    sts.bcast_last = bcast_last;
    sts.quorum_hit = quorum_hit;
    sts.fifo_full  = fifo_full;
  end

  // message produced this cycle
  always_comb begin
    emit_en  = 1'b0;
    emit_res = '{dest: snd, kind: qmn_pkg::K_LOCKED, stamp: st, acq: 1'b0, last: 1'b0};
    unique case (cmd.act)
      qmn_pkg::ACT_DISPATCH: begin
        case (op)
          qmn_pkg::OP_REQUEST: emit_en = !vote_given;
          qmn_pkg::OP_INQUIRE: begin
            emit_en        = map_bit && failure_seen;
            emit_res.kind  = qmn_pkg::K_RELINQUISH;
            emit_res.stamp = own_stamp;
          end
          qmn_pkg::OP_RELINQUISH: emit_en = (wait_count == '0);
          default: emit_en = 1'b0;
        endcase
      end
      qmn_pkg::ACT_POP: begin
        emit_en        = 1'b1;
        emit_res.dest  = q_rd.idx;
        emit_res.stamp = q_rd.stamp;
      end
      qmn_pkg::ACT_REQ_ANS: begin
        emit_en = 1'b1;
        if (send_inquire) begin
          emit_res.dest = vote_holder;
          emit_res.kind = qmn_pkg::K_INQUIRE;
        end else begin
          emit_res.kind = qmn_pkg::K_FAILED;
        end
      end
      qmn_pkg::ACT_FLUSH: begin
        emit_en        = !flush_done;
        emit_res.dest  = d_cur;
        emit_res.kind  = qmn_pkg::K_RELINQUISH;
        emit_res.stamp = own_stamp;
      end
      qmn_pkg::ACT_BCAST: begin
        emit_en        = 1'b1;
        emit_res.dest  = brow_now ? bdest_row : bdest_col;
        emit_res.kind  = bkind;
        emit_res.stamp = own_stamp;
        emit_res.acq   = bacq;
      end
      default: emit_en = 1'b0;
    endcase
  end

  // the newest message waits in staging so the final one can carry last
  assign keep       = emit_en && (ocount < OCW'(qmn_pkg::MAX_OUT));
  assign fifo_push  = staged_v && (keep || (cmd.act == qmn_pkg::ACT_FINISH));
  always_comb begin
    fifo_wdata      = staged;
    fifo_wdata.last = (cmd.act == qmn_pkg::ACT_FINISH);
  end
  assign load = (fcnt != '0) && (!out_valid || out_ready);

  // wait queue port control: circular buffer, insertion walks back from the tail
  always_comb begin
    q_we    = 1'b0;
    q_waddr = QIW'(q_head + ins_k[QIW-1:0]);
    q_wdata = item;
    q_raddr = q_head;
    unique case (cmd.act)
      qmn_pkg::ACT_INS_RD: begin
        q_raddr = QIW'(q_head + ins_k[QIW-1:0] - 1'b1);
        q_we    = (ins_k == '0);
      end
      qmn_pkg::ACT_INS_CMP: begin
        q_we    = 1'b1;
        q_wdata = after_hit ? q_rd : item;
      end
      default: q_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    q_rd <= qmem[q_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.act == qmn_pkg::ACT_LATCH) begin
      op  <= qmn_pkg::op_t'(in_opcode);
      snd <= in_sender;
      st  <= in_stamp;
    end
    if (cmd.act == qmn_pkg::ACT_DISPATCH && op == qmn_pkg::OP_INQUIRE && map_bit &&
        !failure_seen && (dcount < DCW'(DEFER_DEPTH))) begin
      dq[dcount[DIW-1:0]] <= snd;
    end
    if (fifo_push) fmem[wp] <= fifo_wdata;
    if (load) oreg <= fmem[rp];
    if (keep) staged <= emit_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      my_row            <= '0;
      my_col            <= '0;
      is_req            <= 1'b0;
      vote_given        <= 1'b0;
      vote_holder       <= '0;
      vote_holder_stamp <= '0;
      q_head            <= '0;
      wait_count        <= '0;
      ins_k             <= '0;
      dcount            <= '0;
      fk                <= '0;
      grant_map         <= '0;
      grant_count       <= '0;
      failure_seen      <= 1'b0;
      own_stamp         <= '0;
      finished          <= 1'b0;
      bi                <= '0;
      bphase            <= 1'b0;
      bacq              <= 1'b0;
      bkind             <= qmn_pkg::K_REQUEST;
      staged_v          <= 1'b0;
      ocount            <= '0;
      wp                <= '0;
      rp                <= '0;
      fcnt              <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          qmn_pkg::CFG_MY_ROW:       my_row <= cfg_data;
          qmn_pkg::CFG_MY_COL:       my_col <= cfg_data;
          qmn_pkg::CFG_IS_REQUESTER: is_req <= cfg_data[0];
          default: ;
        endcase
      end

      unique case (cmd.act)
        qmn_pkg::ACT_LATCH: ocount <= '0;
        qmn_pkg::ACT_DISPATCH: begin
          case (op)
            qmn_pkg::OP_START: begin
              if (is_req) begin
                own_stamp <= st;
                bi        <= '0;
                bphase    <= 1'b0;
                bacq      <= 1'b0;
                bkind     <= qmn_pkg::K_REQUEST;
              end
            end
            qmn_pkg::OP_REQUEST: begin
              if (!vote_given) begin
                vote_given        <= 1'b1;
                vote_holder       <= snd;
                vote_holder_stamp <= st;
              end else begin
                ins_k <= wait_count;
              end
            end
            qmn_pkg::OP_LOCKED: begin
              if (grant_count != 5'd31) grant_count <= grant_count + 5'd1;
              grant_map[snd] <= 1'b1;
            end
            qmn_pkg::OP_FAILED: begin
              failure_seen <= 1'b1;
              fk           <= '0;
            end
            qmn_pkg::OP_INQUIRE: begin
              if (map_bit) begin
                if (failure_seen) begin
                  grant_map[snd] <= 1'b0;
                  if (grant_count != '0) grant_count <= grant_count - 5'd1;
                end else if (dcount < DCW'(DEFER_DEPTH)) begin
                  dcount <= dcount + 1'b1;
                end
              end
            end
            qmn_pkg::OP_RELINQUISH: begin
              if (wait_count == '0) begin
                vote_given        <= 1'b1;
                vote_holder       <= snd;
                vote_holder_stamp <= st;
              end
            end
            qmn_pkg::OP_RELEASE: begin
              if (wait_count == '0) vote_given <= 1'b0;
            end
            default: ;
          endcase
        end
        qmn_pkg::ACT_POP: begin
          vote_given        <= 1'b1;
          vote_holder       <= q_rd.idx;
          vote_holder_stamp <= q_rd.stamp;
          q_head            <= q_head + 1'b1;
          wait_count        <= wait_count - 1'b1;
          ins_k             <= wait_count - 1'b1;
        end
        qmn_pkg::ACT_INS_RD: begin
          if (ins_k == '0) wait_count <= wait_count + 1'b1;
        end
        qmn_pkg::ACT_INS_CMP: begin
          if (after_hit) ins_k <= ins_k - 1'b1;
          else wait_count <= wait_count + 1'b1;
        end
        qmn_pkg::ACT_FLUSH: begin
          if (!flush_done) begin
            if (grant_map[d_cur]) begin
              grant_map[d_cur] <= 1'b0;
              if (grant_count != '0) grant_count <= grant_count - 5'd1;
            end
            fk <= fk + 1'b1;
          end else begin
            dcount <= '0;
          end
        end
        qmn_pkg::ACT_QUORUM: begin
          if (quorum_hit) begin
            finished <= 1'b1;
            bi       <= '0;
            bphase   <= 1'b0;
            bacq     <= 1'b1;
            bkind    <= qmn_pkg::K_RELEASE;
          end
        end
        qmn_pkg::ACT_BCAST: begin
          bacq <= 1'b0;
          if (brow_now) begin
            bphase <= 1'b1;
          end else begin
            bphase <= 1'b0;
            bi     <= bi + 1'b1;
          end
        end
        default: ;
      endcase

      if (keep) begin
        staged_v <= 1'b1;
        ocount   <= ocount + 1'b1;
      end else if (cmd.act == qmn_pkg::ACT_FINISH) begin
        staged_v <= 1'b0;
      end

      if (fifo_push) wp <= wp + 1'b1;
      if (load) rp <= rp + 1'b1;
      fcnt <= fcnt + FCW'(fifo_push) - FCW'(load);

      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign out_dest  = oreg.dest;
  assign out_kind  = oreg.kind;
  assign out_stamp = oreg.stamp;
  assign out_acq   = oreg.acq;
  assign out_last  = oreg.last;

  `QMN_ASSERT_ALWAYS(a_wait_bound, wait_count <= QCW'(qmn_pkg::QDEPTH), "wait queue overrun")
  `QMN_ASSERT_IMP(a_fifo_room, fifo_push, !fifo_full, "result FIFO overflow")
  `QMN_ASSERT_IMP(a_acq_finished, out_valid && out_acq, finished, "acquired before quorum")
  `QMN_ASSERT_IMP(a_clean_start, cmd.act == qmn_pkg::ACT_LATCH, !staged_v, "stale staged beat")

endmodule

`default_nettype wire

### design/quorum_mutex_node_top.sv
// Quorum mutex node: one node of a grid-quorum distributed lock.
// Depends on qmn_pkg, qmn_in_if, qmn_out_if, qmn_ctrl and qmn_datapath.
//
// msg_in carries one protocol message per beat (start, request, locked, failed,
// inquire, relinquish, release). msg_out carries the outgoing messages; last
// marks the final beat caused by an input message, acquired flags the first
// release beat once the quorum is complete. Messages with no effect produce no beat.
// Configuration (row, column, requester role) is written through cfg_we, cfg_index and
// cfg_data; the user must write it only while the node is idle, as the block has no check.
// One message is processed at a time; msg_in.ready is high between messages.
// Sorted insertion into the wait queue walks its memory one entry at a time through
// a read state and a compare state; while the FIFO has room, broadcasts and the
// inquiry flush issue one beat per cycle.
// Results pass through an 8-deep FIFO and an output register, so a stalled
// receiver only holds the sequencer once the FIFO fills.
// Reset (rst, synchronous) clears vote, queue and grant state and the result path.
`default_nettype none

module quorum_mutex_node_top #(
  parameter int ROWS        = 4,
  parameter int DEFER_DEPTH = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  qmn_in_if.sink          msg_in,
  qmn_out_if.source       msg_out,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [1:0] cfg_data
);

  qmn_pkg::cmd_t cmd;
  qmn_pkg::sts_t sts;

  qmn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (msg_in.valid),
    .in_ready (msg_in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qmn_datapath #(
    .ROWS        (ROWS),
    .DEFER_DEPTH (DEFER_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_opcode (msg_in.opcode),
    .in_sender (msg_in.sender_index),
    .in_stamp  (msg_in.stamp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (msg_out.valid),
    .out_ready (msg_out.ready),
    .out_dest  (msg_out.dest_index),
    .out_kind  (msg_out.msg_kind),
    .out_stamp (msg_out.out_stamp),
    .out_acq   (msg_out.acquired),
    .out_last  (msg_out.last)
  );

endmodule

`default_nettype wire

### bench/quorum_mutex_node_top_test.sv
// Testbench for the quorum mutex node: directed and random message streams with a
// behavioral predictor of voter, requester and quorum logic checked beat by beat.
// Depends on qmn_pkg, qmn_in_if, qmn_out_if and quorum_mutex_node_top.
`timescale 1ns / 1ps

module quorum_mutex_node_top_test;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 64;
  localparam int QUORUM     = 7;
  localparam int DEFER      = 8;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [1:0] cfg_data;

  qmn_in_if  in_ch ();
  qmn_out_if out_ch ();

  quorum_mutex_node_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .msg_in   (in_ch),
    .msg_out  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // node model state
  logic [1:0]      node_row, node_col;
  logic            node_req;
  logic            vote_out;
  logic [3:0]      vote_idx;
  logic [31:0]     vote_stamp;
  qmn_pkg::qent_t  waiters[$];
  logic [3:0]      held_inquiries[$];
  logic [15:0]     granters;
  int              grants;
  logic            fail_seen;
  logic [31:0]     my_stamp;
  logic            lock_done;

  qmn_pkg::res_t step_msgs[$];
  qmn_pkg::res_t pending_msgs[$];

  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  function automatic logic later(qmn_pkg::qent_t a, qmn_pkg::qent_t b);
    return (a.stamp > b.stamp) || ((a.stamp == b.stamp) && (a.idx > b.idx));
  endfunction

  function automatic void put_msg(logic [3:0] dest, qmn_pkg::kind_t k, logic [31:0] st,
                                  logic acq);
    qmn_pkg::res_t r;
    if (step_msgs.size() >= qmn_pkg::MAX_OUT) return;
    r.dest = dest;
    r.kind = k;
    r.stamp = st;
    r.acq = acq;
    r.last = 1'b0;
    step_msgs.push_back(r);
  endfunction

  function automatic void send_to_quorum(qmn_pkg::kind_t k, logic [31:0] st, logic acq_first);
    logic acq;
    acq = acq_first;
    for (int i = 0; i < 4; i++) begin
      if (i != node_col) begin
        put_msg(4'(node_row * 4 + i), k, st, acq);
        acq = 1'b0;
      end
      put_msg(4'(i * 4 + node_col), k, st, acq);
      acq = 1'b0;
    end
  endfunction

  function automatic void enqueue_waiter(logic [3:0] idx, logic [31:0] st);
    qmn_pkg::qent_t e;
    int pos;
    if (waiters.size() >= qmn_pkg::QDEPTH) return;
    e.stamp = st;
    e.idx = idx;
    pos = waiters.size();
    for (int i = 0; i < waiters.size(); i++)
      if (later(waiters[i], e)) begin
        pos = i;
        break;
      end
    waiters.insert(pos, e);
  endfunction

  function automatic void give_vote(logic [3:0] idx, logic [31:0] st);
    vote_out = 1'b1;
    vote_idx = idx;
    vote_stamp = st;
    put_msg(idx, qmn_pkg::K_LOCKED, st, 1'b0);
  endfunction

  function automatic void revoke_grant(logic [3:0] idx);
    if (granters[idx]) begin
      granters[idx] = 1'b0;
      if (grants > 0) grants--;
    end
  endfunction

  // expected outgoing beats for one accepted message
  function automatic void predict_msgs(logic [2:0] opc, logic [3:0] snd, logic [31:0] st);
    qmn_pkg::qent_t e, h;
    logic head_later;
    step_msgs.delete();
    e.stamp = st;
    e.idx = snd;
    case (opc)
      qmn_pkg::OP_START:
        if (node_req) begin
          my_stamp = st;
          send_to_quorum(qmn_pkg::K_REQUEST, st, 1'b0);
        end
      qmn_pkg::OP_REQUEST:
        if (!vote_out) give_vote(snd, st);
        else begin
          enqueue_waiter(snd, st);
          head_later = waiters.size() > 0 && later(e, waiters[0]);
          if (!(vote_stamp < st || head_later || (vote_stamp == st && vote_idx < snd)))
            put_msg(vote_idx, qmn_pkg::K_INQUIRE, st, 1'b0);
          else
            put_msg(snd, qmn_pkg::K_FAILED, st, 1'b0);
        end
      qmn_pkg::OP_LOCKED: begin
        if (grants < 31) grants++;
        granters[snd] = 1'b1;
      end
      qmn_pkg::OP_FAILED: begin
        fail_seen = 1'b1;
        foreach (held_inquiries[k]) begin
          revoke_grant(held_inquiries[k]);
          put_msg(held_inquiries[k], qmn_pkg::K_RELINQUISH, my_stamp, 1'b0);
        end
        held_inquiries.delete();
      end
      qmn_pkg::OP_INQUIRE:
        if (granters[snd]) begin
          if (fail_seen) begin
            revoke_grant(snd);
            put_msg(snd, qmn_pkg::K_RELINQUISH, my_stamp, 1'b0);
          end else if (held_inquiries.size() < DEFER) held_inquiries.push_back(snd);
        end
      qmn_pkg::OP_RELINQUISH:
        if (waiters.size() == 0) give_vote(snd, st);
        else begin
          h = waiters.pop_front();
          give_vote(h.idx, h.stamp);
          enqueue_waiter(snd, st);
        end
      qmn_pkg::OP_RELEASE:
        if (waiters.size() == 0) vote_out = 1'b0;
        else begin
          h = waiters.pop_front();
          give_vote(h.idx, h.stamp);
        end
      default: return;
    endcase
    if (!lock_done && grants == QUORUM) begin
      lock_done = 1'b1;
      send_to_quorum(qmn_pkg::K_RELEASE, my_stamp, 1'b1);
    end
    if (step_msgs.size() > 0) step_msgs[step_msgs.size() - 1].last = 1'b1;
    foreach (step_msgs[i]) pending_msgs.push_back(step_msgs[i]);
  endfunction

  task automatic send_msg(logic [2:0] opc, logic [3:0] snd, logic [31:0] st);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= opc;
    in_ch.sender_index <= snd;
    in_ch.stamp <= st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_msgs(opc, snd, st);
  endtask

  // hold input until every expected beat is out, then let a silent message finish
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      qmn_pkg::CFG_MY_ROW: node_row = val;
      qmn_pkg::CFG_MY_COL: node_col = val;
      qmn_pkg::CFG_IS_REQUESTER: node_req = val[0];
      default: ;
    endcase
  endtask

  task automatic set_node(logic [1:0] row, logic [1:0] col, logic req);
    drain();
    write_cfg(qmn_pkg::CFG_MY_ROW, row);
    write_cfg(qmn_pkg::CFG_MY_COL, col);
    write_cfg(qmn_pkg::CFG_IS_REQUESTER, {1'b0, req});
    cfg_we <= 1'b0;
  endtask

  // mostly small stamps so ties and ordering by index show up
  function automatic logic [31:0] pick_stamp();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1, 2: return $urandom;
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 7);
    endcase
  endfunction

  function automatic logic [3:0] quorum_member();
    int i;
    i = $urandom_range(0, 6);
    if (i < 4) return 4'(node_row * 4 + i);
    return 4'(($urandom_range(0, 3)) * 4 + node_col);
  endfunction

  task automatic test_directed();
    set_node(2'd3, 2'd3, 1'b1);
    send_msg(3'd7, 4'd15, 32'hFFFF_FFFF);
    send_msg(qmn_pkg::OP_START, 4'd0, 32'hFFFF_FFFF);
    send_msg(qmn_pkg::OP_START, 4'd15, 32'd5);
    send_msg(qmn_pkg::OP_REQUEST, 4'd0, 32'd0);
    send_msg(qmn_pkg::OP_REQUEST, 4'd15, 32'hFFFF_FFFF);
    send_msg(qmn_pkg::OP_REQUEST, 4'd1, 32'd0);
    send_msg(qmn_pkg::OP_REQUEST, 4'd0, 32'd0);
    send_msg(qmn_pkg::OP_RELINQUISH, 4'd0, 32'd0);
    send_msg(qmn_pkg::OP_RELEASE, 4'd0, 32'd0);
    send_msg(qmn_pkg::OP_RELEASE, 4'd0, 32'd0);
    send_msg(qmn_pkg::OP_RELEASE, 4'd0, 32'd0);
    send_msg(qmn_pkg::OP_RELEASE, 4'd0, 32'd0);
    send_msg(qmn_pkg::OP_RELINQUISH, 4'd9, 32'h8000_0001);
    send_msg(qmn_pkg::OP_INQUIRE, 4'd12, 32'd3);
    send_msg(qmn_pkg::OP_LOCKED, 4'd12, 32'd0);
    send_msg(qmn_pkg::OP_LOCKED, 4'd12, 32'd0);
    send_msg(qmn_pkg::OP_INQUIRE, 4'd12, 32'd1);
    send_msg(qmn_pkg::OP_LOCKED, 4'd3, 32'hFFFF_FFFF);
    send_msg(qmn_pkg::OP_INQUIRE, 4'd3, 32'd0);
    send_msg(qmn_pkg::OP_FAILED, 4'd7, 32'd0);
    send_msg(qmn_pkg::OP_INQUIRE, 4'd12, 32'd2);
    send_msg(qmn_pkg::OP_START, 4'd0, 32'h5555_AAAA);
  endtask

  // voter only: crowds of requests fill and overflow the wait queue
  task automatic test_voter();
    logic [2:0] opc;
    set_node(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b0);
    for (int n = 0; n < 150; n++) begin
      if (n % 50 < 30)
        opc = ($urandom_range(0, 4) != 0) ? qmn_pkg::OP_REQUEST : qmn_pkg::OP_RELEASE;
      else case ($urandom_range(0, 5))
        0: opc = qmn_pkg::OP_START;
        1, 2: opc = qmn_pkg::OP_RELINQUISH;
        3: opc = qmn_pkg::OP_REQUEST;
        default: opc = qmn_pkg::OP_RELEASE;
      endcase
      send_msg(opc, 4'($urandom_range(0, 15)), pick_stamp());
      if (n == 75) drain();
    end
  endtask

  // requester rounds: start, grants from quorum members, inquiries, failures
  task automatic test_requester();
    logic [3:0] who;
    set_node(2'd0, 2'd0, 1'b1);
    for (int round = 0; round < 12; round++) begin
      if (round == 6) set_node(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'b1);
      send_msg(qmn_pkg::OP_START, 4'($urandom_range(0, 15)), pick_stamp());
      for (int n = 0; n < 16; n++) begin
        who = ($urandom_range(0, 4) != 0) ? quorum_member() : 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0, 1, 2: send_msg(qmn_pkg::OP_LOCKED, who, pick_stamp());
          3, 4, 5: send_msg(qmn_pkg::OP_INQUIRE, who, pick_stamp());
          6: send_msg(qmn_pkg::OP_FAILED, who, pick_stamp());
          7: send_msg(qmn_pkg::OP_REQUEST, who, pick_stamp());
          default:
            send_msg($urandom_range(0, 1) ? qmn_pkg::OP_RELEASE : qmn_pkg::OP_RELINQUISH,
                     who, pick_stamp());
        endcase
      end
    end
  endtask

  task automatic test_noise();
    set_node(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    for (int n = 0; n < 50; n++)
      send_msg(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), $urandom);
  endtask

  // receiver stall pattern: long ready stretches alternate with choppy ones
  int rx_phase = 0;
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1;
    if (rst || rx_phase[7:6] == 2'd0) out_ch.ready <= 1'b1;
    else if (rx_phase[7:6] == 2'd3) out_ch.ready <= ($urandom_range(0, 7) == 0);
    else out_ch.ready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    qmn_pkg::res_t want, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.dest = out_ch.dest_index;
      got.kind = qmn_pkg::kind_t'(out_ch.msg_kind);
      got.stamp = out_ch.out_stamp;
      got.acq = out_ch.acquired;
      got.last = out_ch.last;
      if (pending_msgs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %p", got);
      end else begin
        want = pending_msgs.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("[quorum_mutex_node_top] ERROR");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= '0;
    in_ch.sender_index <= '0;
    in_ch.stamp <= '0;
    node_row = '0; node_col = '0; node_req = 1'b0;
    vote_out = 1'b0; vote_idx = '0; vote_stamp = '0;
    granters = '0; grants = 0; fail_seen = 1'b0; my_stamp = '0; lock_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_voter();
    test_requester();
    test_noise();
    drain();
    if (errors == 0 && pending_msgs.size() == 0) $display("[quorum_mutex_node_top] OK");
    else $display("[quorum_mutex_node_top] ERROR");
    $finish;
  end

endmodule
